FILE: rtl/olfoc_pkg.sv
// ----------------------------------------------------------------------------
// olfoc_pkg
// shared widths, constants, command struct and state codes for the open-loop
// foc pwm generator
// ----------------------------------------------------------------------------
package olfoc_pkg;

   // angle and sine quantization
   localparam int ANGLE_BITS         = 16;
   localparam int SINE_TABLE_ENTRIES = 1024;
   localparam int SINE_IDX_BITS      = $clog2(SINE_TABLE_ENTRIES);
   localparam int X_SHIFT            = 17 - SINE_IDX_BITS;
   localparam int STEP_SHIFT         = 40 - ANGLE_BITS;

   // port widths
   localparam int VEL_W      = 16;
   localparam int PP_W       = 6;
   localparam int VS_W       = 13;
   localparam int DUTY_W     = 7;
   localparam int EANGLE_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   // shared multiplier
   localparam int MUL_A_W = 28;
   localparam int MUL_B_W = 21;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // internal widths
   localparam int Q_W    = 17;
   localparam int TRIG_W = 18;
   localparam int T_W    = 36;
   localparam int K_W    = 37;
   localparam int PH_W   = 40;
   localparam int PSUM_W = 58;
   localparam int VSM_W  = 21;
   localparam int N_W    = 16;
   localparam int QUOT_W = 9;

   // fixed-point constants
   localparam logic signed [MUL_A_W-1:0] PHASE_STEP_K = 28'sd68356528;
   localparam logic        [Q_W-1:0]     SIN_A        = 17'd51472;
   localparam logic        [Q_W-1:0]     SIN_B        = 17'd21024;
   localparam logic signed [MUL_A_W-1:0] SIN_C        = 28'sd2320;
   localparam logic        [Q_W-1:0]     Q15_ONE      = 17'd32768;
   localparam logic signed [MUL_A_W-1:0] SQRT3_X3     = 28'sd170268;
   localparam logic signed [K_W-1:0]     MID_K        = 37'sd10737418240;
   localparam logic signed [MUL_B_W-1:0] RECIP_100    = 21'sd5243;
   localparam int                        RECIP_SHIFT  = 19;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POLE_PAIRS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUPPLY     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MAX   = 2'd2;

   // reset values
   localparam logic [PP_W-1:0]   PP_RESET    = 6'd7;
   localparam logic [VSM_W-1:0]  VSM_RESET   = 21'd254976;   // 3072 * 83
   localparam logic [DUTY_W-1:0] DMAX_RESET  = 7'd70;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_STEP,
      ST_ANG,
      ST_SX0,
      ST_SA0,
      ST_SB0,
      ST_SC0,
      ST_SX1,
      ST_SA1,
      ST_SB1,
      ST_SC1,
      ST_TRIG,
      ST_KHA,
      ST_KLA,
      ST_DIVA,
      ST_KHB,
      ST_KLB,
      ST_DIVB,
      ST_KHC,
      ST_KLC,
      ST_DIVC,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_STEP,
      MUL_ANG,
      MUL_SQ,
      MUL_X2C,
      MUL_T1,
      MUL_TX,
      MUL_COS,
      MUL_KH,
      MUL_KL,
      MUL_RECIP
   } mul_sel_type;

   typedef enum logic [1:0] {
      LEG_A,
      LEG_B,
      LEG_C
   } leg_type;

   typedef struct packed {
      logic        load_vel;
      mul_sel_type mul_sel;
      logic        hi_arg;
      logic        wr_phase;
      logic        wr_e;
      logic        wr_x2;
      logic        wr_q0;
      logic        wr_trig;
      logic        wr_t;
      logic        wr_k;
      leg_type     k_leg;
      logic        wr_ph;
      logic        wr_duty;
      leg_type     duty_leg;
      logic        load_out;
   } cmd_type;

endpackage

FILE: rtl/olfoc_ctrl.sv
// ----------------------------------------------------------------------------
// olfoc_ctrl
// sequencer: walks one tick through the shared multiplier and owns the
// handshakes of both channels
// ----------------------------------------------------------------------------
module olfoc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output olfoc_pkg::cmd_type cmd
);
   import olfoc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_vel = 1'b1;
               state_in     = ST_STEP;
            end
         end
         ST_STEP: begin
            cmd.mul_sel = MUL_STEP;
            state_in    = ST_ANG;
         end
         ST_ANG: begin
            cmd.wr_phase = 1'b1;
            cmd.mul_sel  = MUL_ANG;
            state_in     = ST_SX0;
         end
         ST_SX0: begin
            cmd.wr_e    = 1'b1;
            cmd.mul_sel = MUL_SQ;
            state_in    = ST_SA0;
         end
         ST_SA0: begin
            cmd.wr_x2   = 1'b1;
            cmd.mul_sel = MUL_X2C;
            state_in    = ST_SB0;
         end
         ST_SB0: begin
            cmd.mul_sel = MUL_T1;
            state_in    = ST_SC0;
         end
         ST_SC0: begin
            cmd.mul_sel = MUL_TX;
            state_in    = ST_SX1;
         end
         ST_SX1: begin
            cmd.wr_q0   = 1'b1;
            cmd.mul_sel = MUL_SQ;
            cmd.hi_arg  = 1'b1;
            state_in    = ST_SA1;
         end
         ST_SA1: begin
            cmd.wr_x2   = 1'b1;
            cmd.mul_sel = MUL_X2C;
            state_in    = ST_SB1;
         end
         ST_SB1: begin
            cmd.mul_sel = MUL_T1;
            state_in    = ST_SC1;
         end
         ST_SC1: begin
            cmd.mul_sel = MUL_TX;
            cmd.hi_arg  = 1'b1;
            state_in    = ST_TRIG;
         end
         ST_TRIG: begin
            cmd.wr_trig = 1'b1;
            cmd.mul_sel = MUL_COS;
            state_in    = ST_KHA;
         end
         ST_KHA: begin
            cmd.wr_t    = 1'b1;
            cmd.wr_k    = 1'b1;
            cmd.k_leg   = LEG_A;
            cmd.mul_sel = MUL_KH;
            state_in    = ST_KLA;
         end
         ST_KLA: begin
            cmd.wr_ph   = 1'b1;
            cmd.mul_sel = MUL_KL;
            state_in    = ST_DIVA;
         end
         ST_DIVA: begin
            cmd.mul_sel = MUL_RECIP;
            state_in    = ST_KHB;
         end
         ST_KHB: begin
            cmd.wr_duty  = 1'b1;
            cmd.duty_leg = LEG_A;
            cmd.wr_k     = 1'b1;
            cmd.k_leg    = LEG_B;
            cmd.mul_sel  = MUL_KH;
            state_in     = ST_KLB;
         end
         ST_KLB: begin
            cmd.wr_ph   = 1'b1;
            cmd.mul_sel = MUL_KL;
            state_in    = ST_DIVB;
         end
         ST_DIVB: begin
            cmd.mul_sel = MUL_RECIP;
            state_in    = ST_KHC;
         end
         ST_KHC: begin
            cmd.wr_duty  = 1'b1;
            cmd.duty_leg = LEG_B;
            cmd.wr_k     = 1'b1;
            cmd.k_leg    = LEG_C;
            cmd.mul_sel  = MUL_KH;
            state_in     = ST_KLC;
         end
         ST_KLC: begin
            cmd.wr_ph   = 1'b1;
            cmd.mul_sel = MUL_KL;
            state_in    = ST_DIVC;
         end
         ST_DIVC: begin
            cmd.mul_sel = MUL_RECIP;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // wait here while the output register still holds an untaken beat
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/olfoc_dp.sv
// ----------------------------------------------------------------------------
// olfoc_dp
// datapath: config registers, shaft phase, one shared multiplier with its
// product register, working registers and the result register
// ----------------------------------------------------------------------------
module olfoc_dp (
   input  logic                                         clock,
   input  logic                                         reset,
   input  olfoc_pkg::cmd_type                           cmd,
   input  logic signed [olfoc_pkg::VEL_W-1:0]           req_velocity,
   input  logic                                         csr_wr_en,
   input  logic        [olfoc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic        [olfoc_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   output logic        [olfoc_pkg::DUTY_W-1:0]          rsp_duty_a,
   output logic        [olfoc_pkg::DUTY_W-1:0]          rsp_duty_b,
   output logic        [olfoc_pkg::DUTY_W-1:0]          rsp_duty_c,
   output logic        [olfoc_pkg::EANGLE_W-1:0]        rsp_electrical_angle
);
   import olfoc_pkg::*;

   // config
   logic        [PP_W-1:0]       pp_ff, pp_in;
   logic        [VSM_W-1:0]      vsm_ff, vsm_in;     // supply times 83
   logic        [DUTY_W-1:0]     dmax_ff, dmax_in;
   // control state
   logic        [ANGLE_BITS-1:0] phase_ff, phase_in;
   // working registers
   logic signed [VEL_W-1:0]      vel_ff, vel_in;
   logic        [ANGLE_BITS-1:0] e_ff, e_in;
   logic        [Q_W-1:0]        x2_ff, x2_in;
   logic        [Q_W-1:0]        q0_ff, q0_in;
   logic signed [TRIG_W-1:0]     sv_ff, sv_in;
   logic signed [T_W-1:0]        t_ff, t_in;
   logic signed [K_W-1:0]        k_ff, k_in;
   logic signed [PH_W-1:0]       ph_ff, ph_in;
   logic        [DUTY_W-1:0]     duty_a_ff, duty_a_in;
   logic        [DUTY_W-1:0]     duty_b_ff, duty_b_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   // result register
   logic        [DUTY_W-1:0]     out_a_ff, out_a_in;
   logic        [DUTY_W-1:0]     out_b_ff, out_b_in;
   logic        [DUTY_W-1:0]     out_c_ff, out_c_in;
   logic        [EANGLE_W-1:0]   out_e_ff, out_e_in;

   // combinational
   logic        [39:0]              round_sum;
   logic        [ANGLE_BITS-1:0]    phase_new;
   logic        [ANGLE_BITS-1:0]    e_cur;
   logic        [SINE_IDX_BITS-1:0] idx;
   logic        [Q_W-1:0]           xv;
   logic        [Q_W-1:0]           arg;
   logic        [1:0]               quad;
   logic        [Q_W-1:0]           prod_sh15;
   logic        [Q_W-1:0]           s_mag, c_mag;
   logic signed [TRIG_W-1:0]        sv_cur, cv_cur;
   logic signed [K_W-1:0]           u_term;
   logic signed [K_W-1:0]           k_cur;
   logic signed [PSUM_W-1:0]        p_sum;
   logic        [N_W-1:0]           n_val;
   logic        [QUOT_W-1:0]        quot;
   logic        [DUTY_W-1:0]        duty_clamp;
   logic signed [MUL_A_W-1:0]       mul_a;
   logic signed [MUL_B_W-1:0]       mul_b;
   logic        [VSM_W-1:0]         csr_vs;

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_ff    <= PP_RESET;
         vsm_ff   <= VSM_RESET;
         dmax_ff  <= DMAX_RESET;
         phase_ff <= '0;
      end else begin
         pp_ff    <= pp_in;
         vsm_ff   <= vsm_in;
         dmax_ff  <= dmax_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      vel_ff    <= vel_in;
      e_ff      <= e_in;
      x2_ff     <= x2_in;
      q0_ff     <= q0_in;
      sv_ff     <= sv_in;
      t_ff      <= t_in;
      k_ff      <= k_in;
      ph_ff     <= ph_in;
      duty_a_ff <= duty_a_in;
      duty_b_ff <= duty_b_in;
      prod_ff   <= prod_in;
      out_a_ff  <= out_a_in;
      out_b_ff  <= out_b_in;
      out_c_ff  <= out_c_in;
      out_e_ff  <= out_e_in;
   end

   // shaft phase step, rounded, kept modulo one turn
   always_comb begin
      round_sum = prod_ff[39:0] + (40'd1 << (STEP_SHIFT - 1));
      phase_new = phase_ff + round_sum[39:STEP_SHIFT];
   end

   // sine argument from the quarter-wave position
   always_comb begin
      e_cur = cmd.wr_e ? prod_ff[ANGLE_BITS-1:0] : e_ff;
      idx   = e_cur[ANGLE_BITS-1 -: SINE_IDX_BITS];
      xv    = Q_W'(idx[SINE_IDX_BITS-3:0]) << X_SHIFT;
      arg   = cmd.hi_arg ? (Q15_ONE - xv) : xv;
      quad  = e_ff[ANGLE_BITS-1 -: 2];
      prod_sh15 = prod_ff[31:15];
   end

   // sine and cosine from the two quarter-wave values
   always_comb begin
      s_mag  = quad[0] ? prod_sh15 : q0_ff;
      c_mag  = quad[0] ? q0_ff : prod_sh15;
      sv_cur = quad[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
      cv_cur = (quad[1] ^ quad[0]) ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
   end

   // leg term k: twice the phase voltage per volt of supply
   always_comb begin
      u_term = (K_W'(sv_ff) <<< 16) + (K_W'(sv_ff) <<< 15);
      case (cmd.k_leg)
         LEG_A:   k_cur = MID_K - (u_term <<< 1);
         LEG_B:   k_cur = MID_K + K_W'(t_ff) + u_term;
         LEG_C:   k_cur = MID_K + u_term - K_W'(t_ff);
         default: k_cur = MID_K;
      endcase
   end

   // recombine partial products, floor by 2^39, then divide by 100
   always_comb begin
      p_sum      = (PSUM_W'(ph_ff) <<< 18) + PSUM_W'($signed({1'b0, prod_ff[37:0]}));
      n_val      = (p_sum > 0) ? p_sum[54:39] : '0;
      quot       = prod_ff[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
      duty_clamp = (quot > QUOT_W'(dmax_ff)) ? dmax_ff : quot[DUTY_W-1:0];
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         MUL_STEP: begin
            mul_a = PHASE_STEP_K;
            mul_b = MUL_B_W'(vel_ff);
         end
         MUL_ANG: begin
            mul_a = $signed(MUL_A_W'(phase_new));
            mul_b = $signed(MUL_B_W'(pp_ff));
         end
         MUL_SQ: begin
            mul_a = $signed(MUL_A_W'(arg));
            mul_b = $signed(MUL_B_W'(arg));
         end
         MUL_X2C: begin
            mul_a = SIN_C;
            mul_b = $signed(MUL_B_W'(prod_sh15));
         end
         MUL_T1: begin
            mul_a = $signed(MUL_A_W'(SIN_B - prod_sh15));
            mul_b = $signed(MUL_B_W'(x2_ff));
         end
         MUL_TX: begin
            mul_a = $signed(MUL_A_W'(SIN_A - prod_sh15));
            mul_b = $signed(MUL_B_W'(arg));
         end
         MUL_COS: begin
            mul_a = SQRT3_X3;
            mul_b = MUL_B_W'(cv_cur);
         end
         MUL_KH: begin
            mul_a = MUL_A_W'($signed(k_cur[K_W-1:18]));
            mul_b = $signed(vsm_ff);
         end
         MUL_KL: begin
            mul_a = $signed(MUL_A_W'(k_ff[17:0]));
            mul_b = $signed(vsm_ff);
         end
         MUL_RECIP: begin
            mul_a = $signed(MUL_A_W'(n_val));
            mul_b = RECIP_100;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // supply scaled by 83 at write time
   assign csr_vs = (VSM_W'(csr_wr_data) << 6) + (VSM_W'(csr_wr_data) << 4)
                 + (VSM_W'(csr_wr_data) << 1) + VSM_W'(csr_wr_data);

   always_comb begin
      pp_in     = pp_ff;
      vsm_in    = vsm_ff;
      dmax_in   = dmax_ff;
      phase_in  = phase_ff;
      vel_in    = vel_ff;
      e_in      = e_ff;
      x2_in     = x2_ff;
      q0_in     = q0_ff;
      sv_in     = sv_ff;
      t_in      = t_ff;
      k_in      = k_ff;
      ph_in     = ph_ff;
      duty_a_in = duty_a_ff;
      duty_b_in = duty_b_ff;
      out_a_in  = out_a_ff;
      out_b_in  = out_b_ff;
      out_c_in  = out_c_ff;
      out_e_in  = out_e_ff;
      prod_in   = (cmd.mul_sel != MUL_NONE) ? mul_a * mul_b : prod_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_POLE_PAIRS: pp_in   = csr_wr_data[PP_W-1:0];
            CSR_SUPPLY:     vsm_in  = csr_vs;
            CSR_DUTY_MAX:   dmax_in = csr_wr_data[DUTY_W-1:0];
            default:        ;
         endcase
      end

      if (cmd.load_vel) vel_in   = req_velocity;
      if (cmd.wr_phase) phase_in = phase_new;
      if (cmd.wr_e)     e_in     = prod_ff[ANGLE_BITS-1:0];
      if (cmd.wr_x2)    x2_in    = prod_sh15;
      if (cmd.wr_q0)    q0_in    = prod_sh15;
      if (cmd.wr_trig)  sv_in    = sv_cur;
      if (cmd.wr_t)     t_in     = prod_ff[T_W-1:0];
      if (cmd.wr_k)     k_in     = k_cur;
      if (cmd.wr_ph)    ph_in    = prod_ff[PH_W-1:0];

      if (cmd.wr_duty) begin
         case (cmd.duty_leg)
            LEG_A:   duty_a_in = duty_clamp;
            LEG_B:   duty_b_in = duty_clamp;
            default: ;
         endcase
      end

      if (cmd.load_out) begin
         out_a_in = duty_a_ff;
         out_b_in = duty_b_ff;
         out_c_in = duty_clamp;
         out_e_in = EANGLE_W'({e_ff, 16'b0} >> ANGLE_BITS);
      end
   end

   assign rsp_duty_a           = out_a_ff;
   assign rsp_duty_b           = out_b_ff;
   assign rsp_duty_c           = out_c_ff;
   assign rsp_electrical_angle = out_e_ff;

endmodule

FILE: rtl/open_loop_foc_pwm_generator.sv
// ----------------------------------------------------------------------------
// open_loop_foc_pwm_generator
// open-loop foc: each velocity beat advances the shaft phase, forms the
// electrical angle and gives three clamped pwm duties. one beat in, one beat
// out. the result register loads in the last of the 21 sequencer steps that
// follow the idle step that accepts a beat. the steps are set by the single
// shared 28x21 multiplier that every product of the tick passes through:
// the phase step, the pole-pair product, two polynomial quarter sines of
// four products each, the sqrt(3) cosine term and three products per leg
// for the duty scaling. a new item is taken only in the idle state; a
// finished result waits in its own register, and the sequencer stalls in
// its last step only when that register still holds a beat not yet taken.
// config writes (index 0 pole pairs, 1 supply in q5.8 volts, 2 duty max)
// take effect at once and should be made while no tick is in flight. no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module open_loop_foc_pwm_generator (
   input  logic                                    clock,
   input  logic                                    reset,
   // velocity channel
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [olfoc_pkg::VEL_W-1:0]      req_velocity,
   // duty channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic        [olfoc_pkg::DUTY_W-1:0]     rsp_duty_a,
   output logic        [olfoc_pkg::DUTY_W-1:0]     rsp_duty_b,
   output logic        [olfoc_pkg::DUTY_W-1:0]     rsp_duty_c,
   output logic        [olfoc_pkg::EANGLE_W-1:0]   rsp_electrical_angle,
   // config write port
   input  logic                                    csr_wr_en,
   input  logic        [olfoc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [olfoc_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import olfoc_pkg::*;

   // per-step commands from the sequencer to the datapath
   cmd_type cmd;

   olfoc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // datapath holds the phase accumulator, config and the result register
   olfoc_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_velocity         (req_velocity),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data),
      .rsp_duty_a           (rsp_duty_a),
      .rsp_duty_b           (rsp_duty_b),
      .rsp_duty_c           (rsp_duty_c),
      .rsp_electrical_angle (rsp_electrical_angle)
   );

endmodule
